// ----- sv/deal_pkg.sv -----
// deal_pkg: shared constants, types and des tables for the deal block cipher
`timescale 1ns / 1ps
package deal_pkg;

  localparam int unsigned MaxRoundsDefault = 8;
  localparam int unsigned BlockW = 64;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgKeyWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyWord3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyLength = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSchedKey = 3'd5;

  localparam logic [1:0] KeyLen128 = 2'd0;
  localparam logic [1:0] KeyLen192 = 2'd1;

  localparam logic [63:0] SchedKeyReset = 64'h1234567890ABCDEF;

  localparam logic FuncEncrypt = 1'b0;

  typedef logic [7:0] tab64_t [64];
  typedef logic [7:0] tab56_t [56];
  typedef logic [7:0] tab48_t [48];
  typedef logic [7:0] tab32_t [32];
  typedef logic [3:0] sbox_t [8][64];

  localparam tab64_t TIp = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam tab64_t TFp = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam tab48_t TE = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam tab32_t TP = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam tab56_t TPc1 = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,
    10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,
    14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam tab48_t TPc2 = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  // rounds with a single-bit key rotation
  localparam logic [15:0] ShiftOne = 16'b1000_0001_0000_0011;

  localparam sbox_t TSbox = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,7,1,0,8,6,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  localparam logic [7:0] RoundConst [4] = '{8'h80, 8'h40, 8'h10, 8'h01};

  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = v[64 - int'(TIp[k])];
    return r;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = v[64 - int'(TFp[k])];
    return r;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] r;
    for (int k = 0; k < 56; k++) r[55-k] = v[64 - int'(TPc1[k])];
    return r;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) r[47-k] = v[56 - int'(TPc2[k])];
    return r;
  endfunction

  function automatic logic [31:0] des_f(input logic [31:0] half, input logic [47:0] sub);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] r;
    logic [5:0] v;
    for (int k = 0; k < 48; k++) e[47-k] = half[32 - int'(TE[k])];
    e = e ^ sub;
    for (int k = 0; k < 8; k++) begin
      v = e[47-6*k -: 6];
      s[31-4*k -: 4] = TSbox[k][{v[5], v[0], v[4:1]}];
    end
    for (int k = 0; k < 32; k++) r[31-k] = s[32 - int'(TP[k])];
    return r;
  endfunction

endpackage

// ----- sv/deal_if.sv -----
// deal_if: valid/ready channel interfaces for blocks, results and configuration
`timescale 1ns / 1ps
interface deal_blk_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] block_in_high;
  logic [63:0] block_in_low;
  modport source (output valid, func, block_in_high, block_in_low, input ready);
  modport sink (input valid, func, block_in_high, block_in_low, output ready);
endinterface

interface deal_blk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out_high;
  logic [63:0] block_out_low;
  modport source (output valid, block_out_high, block_out_low, input ready);
  modport sink (input valid, block_out_high, block_out_low, output ready);
endinterface

interface deal_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/deal_block_cipher.sv -----
// deal_block_cipher: iterative deal cipher built around one shared des round unit
// operation: each des pass is one load step plus 16 des rounds; a block takes one
//   pass per deal round (6 or 8 rounds), and the first block after a key write
//   first rebuilds the round keys, one des pass per round key
// blocks are taken only in idle, after the last result enters the output register
// rst_ni async low: clears key words and length, key-ready flag and output valid
`timescale 1ns / 1ps
module deal_block_cipher #(
  parameter int unsigned MAX_ROUNDS = deal_pkg::MaxRoundsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  deal_cfg_if.sink       cfg_i,
  deal_blk_in_if.sink    in_i,
  deal_blk_out_if.source out_o
);
  localparam int unsigned RkW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [2:0] {
    StIdle, StKeyLoad, StKeyDes, StBlkLoad, StBlkDes, StOut
  } state_e;

  state_e state_q;
  logic [63:0] kw_q [4];
  logic [1:0]  klen_q;
  logic [63:0] skey_q;
  logic        ready_keys_q;
  logic        func_q;
  logic [63:0] l_q, r_q;
  logic [63:0] rk_q [MAX_ROUNDS];
  logic [CntW-1:0] idx_q;
  logic [3:0]  dr_q;
  logic [27:0] c_q, d_q;
  logic [31:0] dl_q, drr_q;
  logic        out_valid_q;
  logic [63:0] out_hi_q, out_lo_q;

  logic [CntW-1:0] rounds;
  logic [2:0] words;
  assign rounds = (klen_q[1]) ? CntW'(8 > MAX_ROUNDS ? MAX_ROUNDS : 8)
                              : CntW'(6 > MAX_ROUNDS ? MAX_ROUNDS : 6);
  assign words = klen_q[1] ? 3'd4 : ({1'b0, klen_q} + 3'd2);

  // des round datapath
  logic [1:0]  sh;
  logic [27:0] c_n, d_n;
  logic [31:0] f_out;
  logic [63:0] des_res;
  always_comb begin
    sh = deal_pkg::ShiftOne[dr_q] ? 2'd1 : 2'd2;
    c_n = (sh == 2'd1) ? {c_q[26:0], c_q[27]} : {c_q[25:0], c_q[27:26]};
    d_n = (sh == 2'd1) ? {d_q[26:0], d_q[27]} : {d_q[25:0], d_q[27:26]};
    f_out = deal_pkg::des_f(drr_q, deal_pkg::pc2_perm({c_n, d_n}));
    des_res = deal_pkg::fp_perm({dl_q ^ f_out, drr_q});
  end

  // key schedule input for round key idx_q
  logic [63:0] kx;
  logic [2:0]  kmod;
  logic [RkW-1:0] ridx, rprev;
  logic [2:0]  cdiff;
  always_comb begin
    kmod = (idx_q[2:0] >= words) ? idx_q[2:0] - words : idx_q[2:0];
    if (kmod >= words) kmod = kmod - words;
    rprev = RkW'(idx_q - CntW'(1));
    ridx = RkW'(idx_q);
    cdiff = idx_q[2:0] - words;
    if (idx_q == '0) kx = kw_q[0];
    else begin
      kx = kw_q[kmod[1:0]] ^ rk_q[rprev];
      if (CntW'(words) <= idx_q) kx = kx ^ {56'd0, deal_pkg::RoundConst[cdiff[1:0]]};
    end
  end

  logic [RkW-1:0] bidx;
  logic [63:0] des_key, des_blk, cd_start;
  always_comb begin
    bidx = (func_q == deal_pkg::FuncEncrypt) ? RkW'(idx_q) : RkW'(rounds - CntW'(1) - idx_q);
    if (state_q == StKeyLoad) begin
      des_key = skey_q; des_blk = kx;
    end else begin
      des_key = rk_q[bidx];
      des_blk = (func_q == deal_pkg::FuncEncrypt) ? r_q : l_q;
    end
    cd_start = {8'd0, deal_pkg::pc1_perm(des_key)};
  end

  logic cfg_we;
  logic out_load;
  assign cfg_we = cfg_i.valid && cfg_i.ready;
  // key registers change only between blocks
  assign cfg_i.ready = (state_q == StIdle);
  assign in_i.ready = (state_q == StIdle);
  // finished block moves to the output register once it is free
  assign out_load = (state_q == StOut) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.block_out_high = out_hi_q;
  assign out_o.block_out_low = out_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < 4; i++) kw_q[i] <= '0;
      klen_q <= '0;
      skey_q <= deal_pkg::SchedKeyReset;
      ready_keys_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_hi_q <= '0;
      out_lo_q <= '0;
      idx_q <= '0;
      dr_q <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_i.index)
          deal_pkg::CfgKeyWord0: kw_q[0] <= cfg_i.data;
          deal_pkg::CfgKeyWord1: kw_q[1] <= cfg_i.data;
          deal_pkg::CfgKeyWord2: kw_q[2] <= cfg_i.data;
          deal_pkg::CfgKeyWord3: kw_q[3] <= cfg_i.data;
          deal_pkg::CfgKeyLength: klen_q <= cfg_i.data[1:0];
          deal_pkg::CfgSchedKey: skey_q <= cfg_i.data;
          default: ;
        endcase
        if (cfg_i.index <= deal_pkg::CfgSchedKey) ready_keys_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_hi_q <= l_q;
        out_lo_q <= r_q;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_i.valid && in_i.ready) begin
            func_q <= in_i.func;
            l_q <= in_i.block_in_high;
            r_q <= in_i.block_in_low;
            idx_q <= '0;
            state_q <= (ready_keys_q && !cfg_we) ? StBlkLoad : StKeyLoad;
          end
        end
        StKeyLoad, StBlkLoad: begin
          {dl_q, drr_q} <= deal_pkg::ip_perm(des_blk);
          c_q <= cd_start[55:28];
          d_q <= cd_start[27:0];
          dr_q <= '0;
          state_q <= (state_q == StKeyLoad) ? StKeyDes : StBlkDes;
        end
        StKeyDes, StBlkDes: begin
          c_q <= c_n; d_q <= d_n;
          dl_q <= drr_q; drr_q <= dl_q ^ f_out;
          dr_q <= dr_q + 4'd1;
          if (dr_q == 4'd15) begin
            if (state_q == StKeyDes) begin
              rk_q[ridx] <= des_res;
              if (idx_q == rounds - CntW'(1)) begin
                idx_q <= '0; ready_keys_q <= 1'b1; state_q <= StBlkLoad;
              end else begin
                idx_q <= idx_q + CntW'(1); state_q <= StKeyLoad;
              end
            end else begin
              if (func_q == deal_pkg::FuncEncrypt) begin
                l_q <= r_q; r_q <= des_res ^ l_q;
              end else begin
                r_q <= l_q; l_q <= des_res ^ r_q;
              end
              if (idx_q == rounds - CntW'(1)) state_q <= StOut;
              else begin
                idx_q <= idx_q + CntW'(1); state_q <= StBlkLoad;
              end
            end
          end
        end
        StOut: begin
          if (out_load) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- sv/deal_checker.sv -----
// deal_checker: port-level assertions for deal_block_cipher and its bind
`timescale 1ns / 1ps
module deal_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] out_high,
  input logic [63:0] out_low
);
  // handshake outputs are always driven once out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready, out_valid})) else $error("handshake output unknown");
  // an accepted block occupies the unit, so ready must drop after acceptance
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready) else $error("ready too soon");
  a_no_quick_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !$rose(out_valid)) else $error("result too soon");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("result dropped");
endmodule

bind deal_block_cipher deal_checker u_deal_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_high(out_o.block_out_high), .out_low(out_o.block_out_low)
);
